// ----- rtl/core/itoa_pkg.sv -----
// shared types, constants and helper functions for the integer to ascii digits block
package itoa_pkg;

  localparam int unsigned NumDigits  = 20;
  localparam int unsigned DigitIdxW  = $clog2(NumDigits);
  localparam int unsigned ValueW     = 64;
  localparam int unsigned ConvSteps  = 16;
  localparam int unsigned BitsPerStep = ValueW / ConvSteps;
  localparam int unsigned StepCntW   = $clog2(ConvSteps);

  localparam logic       ModeDec   = 1'b0;
  localparam logic       ModeHex   = 1'b1;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [3:0] DecRadix  = 4'd10;

  typedef struct packed {
    logic              mode;
    logic [ValueW-1:0] value;
    logic              plus_sign;
    logic              upper_case;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_item_t;

  typedef logic [NumDigits-1:0][3:0] digits_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic count;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic in_mode;
    logic has_sign;
    logic out_free;
    logic idx_zero;
  } status_t;

  // one digit to its ascii character
  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] c;
    if (d < DecRadix) begin
      c = CharZero + {4'b0, d};
    end else if (upper) begin
      c = CharUpA + {4'b0, d - DecRadix};
    end else begin
      c = CharLowA + {4'b0, d - DecRadix};
    end
    return c;
  endfunction

  // shift-and-add-3 over several input bits
  function automatic logic [NumDigits*4+ValueW-1:0] dabble(
      logic [NumDigits*4+ValueW-1:0] s);
    logic [NumDigits*4+ValueW-1:0] t;
    logic [3:0]                    d;
    t = s;
    for (int b = 0; b < BitsPerStep; b++) begin
      for (int i = 0; i < NumDigits; i++) begin
        d = t[ValueW+4*i +: 4];
        if (d >= 4'd5) begin
          t[ValueW+4*i +: 4] = d + 4'd3;
        end
      end
      t = {t[NumDigits*4+ValueW-2:0], 1'b0};
    end
    return t;
  endfunction

  // index of the most significant nonzero digit, zero when all are zero
  function automatic logic [DigitIdxW-1:0] top_digit(digits_t v);
    logic [DigitIdxW-1:0] top;
    top = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (v[i] != 4'd0) begin
        top = DigitIdxW'(i);
      end
    end
    return top;
  endfunction

endpackage

// ----- rtl/core/itoa_dp.sv -----
// datapath: magnitude, digit conversion, sign and character output register
module itoa_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  itoa_pkg::in_item_t  in_item,
  input  itoa_pkg::cmd_t      cmd,
  output itoa_pkg::status_t   status,
  output logic                out_valid,
  input  logic                out_stall,
  output itoa_pkg::out_item_t out_item
);

  logic [itoa_pkg::ValueW-1:0]    mag_r, mag_nxt;
  itoa_pkg::digits_t              bcd_r, bcd_nxt;
  logic [itoa_pkg::DigitIdxW-1:0] idx_r, idx_nxt;
  logic                           has_sign_r, has_sign_nxt;
  logic [7:0]                     sign_char_r, sign_char_nxt;
  logic                           upper_r, upper_nxt;
  logic                           out_valid_r, out_valid_nxt;
  itoa_pkg::out_item_t            out_item_r, out_item_nxt;

  logic                           neg;
  logic [itoa_pkg::ValueW-1:0]    abs_val;
  logic [itoa_pkg::NumDigits*4+itoa_pkg::ValueW-1:0] dd;

  assign neg     = in_item.value[itoa_pkg::ValueW-1];
  assign abs_val = neg ? (~in_item.value + itoa_pkg::ValueW'(1)) : in_item.value;
  assign dd      = itoa_pkg::dabble({bcd_r, mag_r});

  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    idx_nxt       = idx_r;
    has_sign_nxt  = has_sign_r;
    sign_char_nxt = sign_char_r;
    upper_nxt     = upper_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_item_nxt  = out_item_r;
    if (cmd.load) begin
      upper_nxt = in_item.upper_case;
      if (in_item.mode == itoa_pkg::ModeHex) begin
        mag_nxt      = '0;
        bcd_nxt      = itoa_pkg::digits_t'(in_item.value);
        has_sign_nxt = 1'b0;
      end else begin
        mag_nxt      = abs_val;
        bcd_nxt      = '0;
        has_sign_nxt = neg | in_item.plus_sign;
      end
      sign_char_nxt = neg ? itoa_pkg::CharMinus : itoa_pkg::CharPlus;
    end
    if (cmd.conv_step) begin
      bcd_nxt = dd[itoa_pkg::NumDigits*4+itoa_pkg::ValueW-1:itoa_pkg::ValueW];
      mag_nxt = dd[itoa_pkg::ValueW-1:0];
    end
    if (cmd.count) begin
      idx_nxt = itoa_pkg::top_digit(bcd_r);
    end
    if (cmd.emit_sign) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.char_out = sign_char_r;
      out_item_nxt.last     = 1'b0;
    end
    if (cmd.emit_digit) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.char_out = itoa_pkg::digit_char(bcd_r[idx_r], upper_r);
      out_item_nxt.last     = (idx_r == '0);
      idx_nxt               = idx_r - itoa_pkg::DigitIdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    mag_r       <= mag_nxt;
    bcd_r       <= bcd_nxt;
    idx_r       <= idx_nxt;
    has_sign_r  <= has_sign_nxt;
    sign_char_r <= sign_char_nxt;
    upper_r     <= upper_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign status.in_mode  = in_item.mode;
  assign status.has_sign = has_sign_r;
  assign status.out_free = ~out_valid_r | ~out_stall;
  assign status.idx_zero = (idx_r == '0);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/core/itoa_ctrl.sv -----
// controller: sequences load, conversion, digit count and character emission
module itoa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  itoa_pkg::status_t status,
  output itoa_pkg::cmd_t    cmd
);

  itoa_pkg::state_t              state_r, state_nxt;
  logic [itoa_pkg::StepCntW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = (status.in_mode == itoa_pkg::ModeHex) ? itoa_pkg::ST_COUNT
                                                            : itoa_pkg::ST_CONV;
        end
      end
      itoa_pkg::ST_CONV: begin
        cnt_nxt = cnt_r + itoa_pkg::StepCntW'(1);
        if (cnt_r == '1) begin
          state_nxt = itoa_pkg::ST_COUNT;
        end
      end
      itoa_pkg::ST_COUNT: begin
        state_nxt = status.has_sign ? itoa_pkg::ST_SIGN : itoa_pkg::ST_DIGITS;
      end
      itoa_pkg::ST_SIGN: begin
        if (status.out_free) begin
          state_nxt = itoa_pkg::ST_DIGITS;
        end
      end
      itoa_pkg::ST_DIGITS: begin
        if (status.out_free && status.idx_zero) begin
          state_nxt = itoa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = itoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      itoa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      itoa_pkg::ST_CONV:   cmd.conv_step  = 1'b1;
      itoa_pkg::ST_COUNT:  cmd.count      = 1'b1;
      itoa_pkg::ST_SIGN:   cmd.emit_sign  = status.out_free;
      itoa_pkg::ST_DIGITS: cmd.emit_digit = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itoa_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/integer_to_ascii_digits.sv -----
// top level of the integer to ascii digits block
// Renders one 64-bit number per input transfer as ASCII characters, most significant
// first, one output transfer per character with last set on the final one. Decimal mode
// reads the value as signed and prefixes '-' (or '+' when plus_sign is set); hex mode is
// unsigned with no prefix. One number is worked on at a time: a new input transfer is
// taken only once the last character of the previous number has been handed to the
// output register. A number gives 1 to 20 characters with sign. Work goes through the
// load cycle, the shift-and-add-3 conversion (four bits a cycle, decimal mode only), the
// digit count cycle and the single output register that sends one character per cycle
// when not stalled.
module integer_to_ascii_digits (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  itoa_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output itoa_pkg::out_item_t out_item
);

  itoa_pkg::cmd_t    cmd;
  itoa_pkg::status_t status;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  itoa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a number is in progress");

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_sign, cmd.emit_digit, cmd.load, cmd.conv_step, cmd.count}))
    else $error("conflicting datapath commands");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_digit) |-> !(out_valid && out_stall))
    else $error("held output overwritten");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_digit && status.idx_zero) |=> !in_stall)
    else $error("block not ready after final character");
`endif

endmodule
